@@ design/imuint_pkg.sv @@
// Package for the strapdown Euler integrator: payload structs, fixed-point constants,
// register-file slot numbers and the microprogram that drives the shared multiplier.
// Depends on nothing; used by imuint_mul and imu_strapdown_euler_integrator.
package imuint_pkg;

  typedef struct packed {
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic [62:0]        timestamp_ns;
  } imu_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic [62:0]        stamp_out;
  } imu_out_t;

  localparam int unsigned GravW = 21;
  localparam int unsigned RfAw  = 5;

  localparam logic signed [63:0] ONE_Q30   = 64'sd1073741824;
  localparam logic signed [63:0] THREE_Q30 = 64'sd3221225472;
  localparam logic signed [63:0] LIM48_POS = 64'sd140737488355327;
  localparam logic signed [63:0] LIM48_NEG = -64'sd140737488355328;

  // dt in Q30 seconds is round(d * 2^30 / 10^9), which equals
  // floor((d * 2^21 + DT_BIAS) / DT_DIV) for d in nanoseconds.
  localparam logic [20:0] DT_DIV   = 21'd1953125;
  localparam logic [21:0] DT_DIV2  = 22'd3906250;
  localparam logic [19:0] DT_BIAS  = 20'd976562;
  localparam logic [32:0] DT_RECIP = 33'd4611686018;  // floor(2^53 / DT_DIV)

  // Rounding shift and magnitude limit of one multiplication.
  typedef enum logic [2:0] {SH_RAW, SH_FRAC, SH_29, SH_30, SH_31} sh_e;
  typedef enum logic [2:0] {LIM_NONE, LIM_31, LIM_33, LIM_40, LIM_50, LIM_60} lim_e;
  typedef enum logic [1:0] {WB_SET, WB_ADD, WB_SAT} wb_e;
  typedef enum logic [3:0] {
    OP_MUL, OP_CONST, OP_RND, OP_SEED, OP_GRAV, OP_NORM, OP_LOOP, OP_END
  } op_e;
  typedef enum logic {CST_ONE, CST_THREE} cst_e;

  typedef struct packed {
    sh_e  sh;
    lim_e lim;
  } mul_ctl_t;

  typedef struct packed {
    op_e             op;
    logic [RfAw-1:0] dst;
    logic [RfAw-1:0] src_a;
    logic [RfAw-1:0] src_b;
    sh_e             sh;
    lim_e            lim;
    wb_e             wb;
    logic            neg;
    cst_e            cst;
  } uop_t;

  // Register-file slots.
  localparam logic [RfAw-1:0] RF_QW = 5'd0,  RF_QX = 5'd1,  RF_QY = 5'd2,  RF_QZ = 5'd3;
  localparam logic [RfAw-1:0] RF_VX = 5'd4,  RF_VY = 5'd5,  RF_VZ = 5'd6;
  localparam logic [RfAw-1:0] RF_PX = 5'd7,  RF_PY = 5'd8,  RF_PZ = 5'd9;
  localparam logic [RfAw-1:0] RF_GX = 5'd10, RF_GY = 5'd11, RF_GZ = 5'd12;
  localparam logic [RfAw-1:0] RF_AX = 5'd13, RF_AY = 5'd14, RF_AZ = 5'd15;
  localparam logic [RfAw-1:0] RF_DT = 5'd16;
  localparam logic [RfAw-1:0] RF_C0 = 5'd17, RF_C1 = 5'd18, RF_C2 = 5'd19, RF_C3 = 5'd20;
  localparam logic [RfAw-1:0] RF_N2 = 5'd17;  // shares the slot of C0, free by then
  localparam logic [RfAw-1:0] RF_N  = 5'd21, RF_Y = 5'd22, RF_Y2 = 5'd23, RF_T = 5'd24;
  localparam logic [RfAw-1:0] RF_R0 = 5'd25, RF_R1 = 5'd26, RF_R2 = 5'd27;
  localparam logic [RfAw-1:0] RF_W0 = 5'd28, RF_W1 = 5'd29, RF_W2 = 5'd30;

  localparam int unsigned PcW = 7;
  localparam logic [PcW-1:0] PC_NEWTON = 7'd23;
  localparam logic [PcW-1:0] PC_ROT    = 7'd32;

  function automatic uop_t u_mul(logic [RfAw-1:0] d, logic [RfAw-1:0] a,
                                 logic [RfAw-1:0] b, sh_e sh, lim_e lim,
                                 wb_e wb, logic neg);
    uop_t u;
    u = '{op: OP_MUL, dst: d, src_a: a, src_b: b, sh: sh, lim: lim, wb: wb,
          neg: neg, cst: CST_ONE};
    return u;
  endfunction

  function automatic uop_t u_op(op_e op, logic [RfAw-1:0] d, logic [RfAw-1:0] a,
                                cst_e cst);
    uop_t u;
    u = '{op: op, dst: d, src_a: a, src_b: a, sh: SH_RAW, lim: LIM_NONE, wb: WB_SET,
          neg: 1'b0, cst: cst};
    return u;
  endfunction

  function automatic uop_t uop_at(logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      // Quaternion rate q * (0, w), Q30.
      7'd0:  u = u_mul(RF_C0, RF_QX, RF_GX, SH_FRAC, LIM_60, WB_SET, 1'b1);
      7'd1:  u = u_mul(RF_C0, RF_QY, RF_GY, SH_FRAC, LIM_60, WB_ADD, 1'b1);
      7'd2:  u = u_mul(RF_C0, RF_QZ, RF_GZ, SH_FRAC, LIM_60, WB_ADD, 1'b1);
      7'd3:  u = u_mul(RF_C1, RF_QW, RF_GX, SH_FRAC, LIM_60, WB_SET, 1'b0);
      7'd4:  u = u_mul(RF_C1, RF_QY, RF_GZ, SH_FRAC, LIM_60, WB_ADD, 1'b0);
      7'd5:  u = u_mul(RF_C1, RF_QZ, RF_GY, SH_FRAC, LIM_60, WB_ADD, 1'b1);
      7'd6:  u = u_mul(RF_C2, RF_QW, RF_GY, SH_FRAC, LIM_60, WB_SET, 1'b0);
      7'd7:  u = u_mul(RF_C2, RF_QX, RF_GZ, SH_FRAC, LIM_60, WB_ADD, 1'b1);
      7'd8:  u = u_mul(RF_C2, RF_QZ, RF_GX, SH_FRAC, LIM_60, WB_ADD, 1'b0);
      7'd9:  u = u_mul(RF_C3, RF_QW, RF_GZ, SH_FRAC, LIM_60, WB_SET, 1'b0);
      7'd10: u = u_mul(RF_C3, RF_QX, RF_GY, SH_FRAC, LIM_60, WB_ADD, 1'b0);
      7'd11: u = u_mul(RF_C3, RF_QY, RF_GX, SH_FRAC, LIM_60, WB_ADD, 1'b1);
      7'd12: u = u_mul(RF_QW, RF_C0, RF_DT, SH_31, LIM_40, WB_ADD, 1'b0);
      7'd13: u = u_mul(RF_QX, RF_C1, RF_DT, SH_31, LIM_40, WB_ADD, 1'b0);
      7'd14: u = u_mul(RF_QY, RF_C2, RF_DT, SH_31, LIM_40, WB_ADD, 1'b0);
      7'd15: u = u_mul(RF_QZ, RF_C3, RF_DT, SH_31, LIM_40, WB_ADD, 1'b0);
      7'd16: u = u_op(OP_NORM, RF_QW, RF_QW, CST_ONE);
      // Sum of squares of the scaled quaternion, Q60.
      7'd17: u = u_mul(RF_N2, RF_QW, RF_QW, SH_RAW, LIM_NONE, WB_SET, 1'b0);
      7'd18: u = u_mul(RF_N2, RF_QX, RF_QX, SH_RAW, LIM_NONE, WB_ADD, 1'b0);
      7'd19: u = u_mul(RF_N2, RF_QY, RF_QY, SH_RAW, LIM_NONE, WB_ADD, 1'b0);
      7'd20: u = u_mul(RF_N2, RF_QZ, RF_QZ, SH_RAW, LIM_NONE, WB_ADD, 1'b0);
      7'd21: u = u_op(OP_RND, RF_N, RF_N2, CST_ONE);
      7'd22: u = u_op(OP_SEED, RF_Y, RF_N2, CST_ONE);
      // Newton step y = y * (3 - n*y*y) / 2.
      7'd23: u = u_mul(RF_Y2, RF_Y, RF_Y, SH_30, LIM_40, WB_SET, 1'b0);
      7'd24: u = u_op(OP_CONST, RF_T, RF_T, CST_THREE);
      7'd25: u = u_mul(RF_T, RF_N, RF_Y2, SH_30, LIM_40, WB_ADD, 1'b1);
      7'd26: u = u_mul(RF_Y, RF_T, RF_Y, SH_31, LIM_33, WB_SET, 1'b0);
      7'd27: u = u_op(OP_LOOP, RF_Y, RF_Y, CST_ONE);
      7'd28: u = u_mul(RF_QW, RF_QW, RF_Y, SH_30, LIM_31, WB_SET, 1'b0);
      7'd29: u = u_mul(RF_QX, RF_QX, RF_Y, SH_30, LIM_31, WB_SET, 1'b0);
      7'd30: u = u_mul(RF_QY, RF_QY, RF_Y, SH_30, LIM_31, WB_SET, 1'b0);
      7'd31: u = u_mul(RF_QZ, RF_QZ, RF_Y, SH_30, LIM_31, WB_SET, 1'b0);
      // Rotation matrix, one row at a time, then the world force of that row.
      7'd32: u = u_op(OP_CONST, RF_R0, RF_R0, CST_ONE);
      7'd33: u = u_mul(RF_R0, RF_QY, RF_QY, SH_29, LIM_60, WB_ADD, 1'b1);
      7'd34: u = u_mul(RF_R0, RF_QZ, RF_QZ, SH_29, LIM_60, WB_ADD, 1'b1);
      7'd35: u = u_mul(RF_R1, RF_QX, RF_QY, SH_29, LIM_60, WB_SET, 1'b0);
      7'd36: u = u_mul(RF_R1, RF_QW, RF_QZ, SH_29, LIM_60, WB_ADD, 1'b1);
      7'd37: u = u_mul(RF_R2, RF_QX, RF_QZ, SH_29, LIM_60, WB_SET, 1'b0);
      7'd38: u = u_mul(RF_R2, RF_QW, RF_QY, SH_29, LIM_60, WB_ADD, 1'b0);
      7'd39: u = u_mul(RF_W0, RF_R0, RF_AX, SH_30, LIM_60, WB_SET, 1'b0);
      7'd40: u = u_mul(RF_W0, RF_R1, RF_AY, SH_30, LIM_60, WB_ADD, 1'b0);
      7'd41: u = u_mul(RF_W0, RF_R2, RF_AZ, SH_30, LIM_60, WB_ADD, 1'b0);
      7'd42: u = u_mul(RF_R0, RF_QX, RF_QY, SH_29, LIM_60, WB_SET, 1'b0);
      7'd43: u = u_mul(RF_R0, RF_QW, RF_QZ, SH_29, LIM_60, WB_ADD, 1'b0);
      7'd44: u = u_op(OP_CONST, RF_R1, RF_R1, CST_ONE);
      7'd45: u = u_mul(RF_R1, RF_QX, RF_QX, SH_29, LIM_60, WB_ADD, 1'b1);
      7'd46: u = u_mul(RF_R1, RF_QZ, RF_QZ, SH_29, LIM_60, WB_ADD, 1'b1);
      7'd47: u = u_mul(RF_R2, RF_QY, RF_QZ, SH_29, LIM_60, WB_SET, 1'b0);
      7'd48: u = u_mul(RF_R2, RF_QW, RF_QX, SH_29, LIM_60, WB_ADD, 1'b1);
      7'd49: u = u_mul(RF_W1, RF_R0, RF_AX, SH_30, LIM_60, WB_SET, 1'b0);
      7'd50: u = u_mul(RF_W1, RF_R1, RF_AY, SH_30, LIM_60, WB_ADD, 1'b0);
      7'd51: u = u_mul(RF_W1, RF_R2, RF_AZ, SH_30, LIM_60, WB_ADD, 1'b0);
      7'd52: u = u_mul(RF_R0, RF_QX, RF_QZ, SH_29, LIM_60, WB_SET, 1'b0);
      7'd53: u = u_mul(RF_R0, RF_QW, RF_QY, SH_29, LIM_60, WB_ADD, 1'b1);
      7'd54: u = u_mul(RF_R1, RF_QY, RF_QZ, SH_29, LIM_60, WB_SET, 1'b0);
      7'd55: u = u_mul(RF_R1, RF_QW, RF_QX, SH_29, LIM_60, WB_ADD, 1'b0);
      7'd56: u = u_op(OP_CONST, RF_R2, RF_R2, CST_ONE);
      7'd57: u = u_mul(RF_R2, RF_QX, RF_QX, SH_29, LIM_60, WB_ADD, 1'b1);
      7'd58: u = u_mul(RF_R2, RF_QY, RF_QY, SH_29, LIM_60, WB_ADD, 1'b1);
      7'd59: u = u_mul(RF_W2, RF_R0, RF_AX, SH_30, LIM_60, WB_SET, 1'b0);
      7'd60: u = u_mul(RF_W2, RF_R1, RF_AY, SH_30, LIM_60, WB_ADD, 1'b0);
      7'd61: u = u_mul(RF_W2, RF_R2, RF_AZ, SH_30, LIM_60, WB_ADD, 1'b0);
      7'd62: u = u_op(OP_GRAV, RF_W2, RF_W2, CST_ONE);
      // Velocity first, then position with the new velocity.
      7'd63: u = u_mul(RF_VX, RF_W0, RF_DT, SH_30, LIM_50, WB_SAT, 1'b0);
      7'd64: u = u_mul(RF_PX, RF_VX, RF_DT, SH_30, LIM_50, WB_SAT, 1'b0);
      7'd65: u = u_mul(RF_VY, RF_W1, RF_DT, SH_30, LIM_50, WB_SAT, 1'b0);
      7'd66: u = u_mul(RF_PY, RF_VY, RF_DT, SH_30, LIM_50, WB_SAT, 1'b0);
      7'd67: u = u_mul(RF_VZ, RF_W2, RF_DT, SH_30, LIM_50, WB_SAT, 1'b0);
      7'd68: u = u_mul(RF_PZ, RF_VZ, RF_DT, SH_30, LIM_50, WB_SAT, 1'b0);
      default: u = u_op(OP_END, RF_QW, RF_QW, CST_ONE);
    endcase
    return u;
  endfunction

endpackage

@@ design/imu_strapdown_euler_integrator.sv @@
// Strapdown inertial integrator: first-order quaternion update, Newton renormalization,
// rotation of force to world, gravity removal, velocity and position integration.
// Steps: dt division, 57 + 3*NORM_ITERATIONS products on the shared multiplier,
// normalizing shift, 7 + 2*NORM_ITERATIONS single steps; one sample at a time, a held pose
// stalls the input.
// Reset: identity attitude, zero position and velocity, first sample only sets the time.
module imu_strapdown_euler_integrator #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned NORM_ITERATIONS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  imuint_pkg::imu_in_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output imuint_pkg::imu_out_t         out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [imuint_pkg::GravW-1:0] cfg_data_i
);
  import imuint_pkg::*;

  localparam logic [GravW-1:0] GravReset =
    GravW'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam int unsigned ItW = $clog2(NORM_ITERATIONS) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_FETCH, S_LDB, S_WAIT, S_NMAX, S_NSRCH, S_NAPPLY
  } state_e;

  state_e             state_q;
  logic [PcW-1:0]     pc_q;
  logic [ItW-1:0]     iter_q;
  logic               first_q;
  logic [62:0]        last_q, stamp_q;
  logic [GravW-1:0]   gravity_q;
  logic [31:0]        d_q;
  logic [32:0]        quot_q;
  logic               cnt_q;
  logic [1:0]         idx_q;
  logic [47:0]        m_q;
  logic [4:0]         k_q;
  logic               dir_q, zero_q;
  logic signed [63:0] opa_q;
  logic               out_valid_q;
  imu_out_t           out_q;
  logic signed [63:0] rf_q [32];

  uop_t               uop;
  mul_ctl_t           mul_ctl;
  logic [RfAw-1:0]    rd_addr;
  logic signed [63:0] rd_data;
  logic               wr_en;
  logic [RfAw-1:0]    wr_addr;
  logic signed [63:0] wr_data;
  logic               mul_start, mul_done;
  logic signed [63:0] mul_res, prod, acc_sum;
  logic [63:0]        rd_abs;
  logic [47:0]        sh_mag;
  logic [64:0]        dt_est;
  logic [52:0]        dt_num;
  logic [53:0]        dt_back, dt_rem;
  logic [33:0]        dt_q;
  logic [62:0]        now, d_full;
  logic [31:0]        d_sat;
  logic               in_fire;
  logic               out_load;

  assign uop     = uop_at(pc_q);
  assign mul_ctl = '{sh: uop.sh, lim: uop.lim};
  assign in_fire = in_valid_i && in_ready_o;
  assign now     = in_data_i.timestamp_ns;
  assign d_full  = (now >= last_q) ? now - last_q : '0;
  assign d_sat   = (d_full > 63'h0_FFFF_FFFF) ? '1 : d_full[31:0];

  // The reciprocal estimate is low by at most two; the remainder picks the exact quotient.
  assign dt_est  = 65'(d_q) * 65'(DT_RECIP);
  assign dt_num  = {d_q, 21'b0} + 53'(DT_BIAS);
  assign dt_back = 54'(quot_q) * 54'(DT_DIV);
  assign dt_rem  = {1'b0, dt_num} - dt_back;
  assign dt_q    = {1'b0, quot_q} + 34'(dt_rem >= 54'(DT_DIV)) + 34'(dt_rem >= 54'(DT_DIV2));

  assign out_load = (state_q == S_FETCH) && (uop.op == OP_END) &&
                    (!out_valid_q || out_ready_i);

  always_comb begin
    unique case (state_q)
      S_LDB:            rd_addr = uop.src_b;
      S_WAIT:           rd_addr = uop.dst;
      S_NMAX, S_NAPPLY: rd_addr = RF_QW + RfAw'(idx_q);
      default:          rd_addr = uop.src_a;
    endcase
  end
  assign rd_data = rf_q[rd_addr];
  assign rd_abs  = rd_data[63] ? 64'(-rd_data) : 64'(rd_data);
  assign sh_mag  = dir_q ? (rd_abs[47:0] >> k_q) : (rd_abs[47:0] << k_q);
  assign prod    = uop.neg ? -mul_res : mul_res;
  assign acc_sum = rd_data + prod;

  // Shared write port of the register file; the sample load writes the sensor slots separately.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = uop.dst;
    wr_data = '0;
    unique case (state_q)
      S_DIV: begin
        wr_en   = !cnt_q;
        wr_addr = RF_DT;
        wr_data = {30'b0, dt_q};
      end
      S_FETCH: begin
        unique case (uop.op)
          OP_CONST: begin
            wr_en   = 1'b1;
            wr_data = (uop.cst == CST_THREE) ? THREE_Q30 : ONE_Q30;
          end
          OP_RND: begin
            wr_en   = 1'b1;
            wr_data = (rd_data + 64'sd536870912) >>> 30;
          end
          OP_SEED: begin
            wr_en = 1'b1;
            priority if (rd_data >= 64'sh2000_0000_0000_0000) wr_data = 64'sd644245094;
            else if (rd_data >= 64'sh1000_0000_0000_0000) wr_data = 64'sd912680550;
            else if (rd_data >= 64'sh0800_0000_0000_0000) wr_data = 64'sd1288490189;
            else wr_data = 64'sd1825361101;
          end
          OP_GRAV: begin
            wr_en   = 1'b1;
            wr_data = rd_data - $signed({43'b0, gravity_q});
          end
          default: ;
        endcase
      end
      S_WAIT: begin
        wr_en = mul_done;
        unique case (uop.wb)
          WB_ADD:  wr_data = acc_sum;
          WB_SAT: begin
            priority if (acc_sum > LIM48_POS) wr_data = LIM48_POS;
            else if (acc_sum < LIM48_NEG) wr_data = LIM48_NEG;
            else wr_data = acc_sum;
          end
          default: wr_data = prod;
        endcase
      end
      S_NAPPLY: begin
        wr_en   = 1'b1;
        wr_addr = RF_QW + RfAw'(idx_q);
        if (zero_q) begin
          wr_data = (idx_q == 2'd0) ? ONE_Q30 : '0;
        end else begin
          wr_data = rd_data[63] ? -$signed({16'b0, sh_mag}) : $signed({16'b0, sh_mag});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) begin
        rf_q[i] <= (i == int'(RF_QW)) ? ONE_Q30 : '0;
      end
    end else begin
      if (in_fire) begin
        rf_q[RF_GX] <= 64'(in_data_i.gyro_x);
        rf_q[RF_GY] <= 64'(in_data_i.gyro_y);
        rf_q[RF_GZ] <= 64'(in_data_i.gyro_z);
        rf_q[RF_AX] <= 64'(in_data_i.accel_x);
        rf_q[RF_AY] <= 64'(in_data_i.accel_y);
        rf_q[RF_AZ] <= 64'(in_data_i.accel_z);
      end
      if (wr_en) begin
        rf_q[wr_addr] <= wr_data;
      end
    end
  end

  assign mul_start = (state_q == S_LDB);

  imuint_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .ctl_i  (mul_ctl),
    .a_i    (opa_q),
    .b_i    (rd_data),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      iter_q      <= '0;
      first_q     <= 1'b1;
      last_q      <= '0;
      gravity_q   <= GravReset;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= 1'b0;
      zero_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gravity_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            last_q  <= now;
            stamp_q <= now;
            first_q <= 1'b0;
            if (!first_q) begin
              d_q     <= d_sat;
              cnt_q   <= 1'b1;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // Reciprocal estimate while cnt_q is set, then the exact dt is written and fetch begins.
          cnt_q <= 1'b0;
          if (cnt_q) begin
            quot_q <= dt_est[64:32];
          end else begin
            pc_q    <= '0;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          unique case (uop.op)
            OP_MUL: begin
              opa_q   <= rd_data;
              state_q <= S_LDB;
            end
            OP_NORM: begin
              idx_q   <= '0;
              m_q     <= '0;
              k_q     <= '0;
              dir_q   <= 1'b0;
              zero_q  <= 1'b0;
              state_q <= S_NMAX;
            end
            OP_LOOP: begin
              if (iter_q == ItW'(NORM_ITERATIONS - 1)) begin
                iter_q <= '0;
                pc_q   <= pc_q + PcW'(1);
              end else begin
                iter_q <= iter_q + ItW'(1);
                pc_q   <= PC_NEWTON;
              end
            end
            OP_END: begin
              if (out_load) begin
                out_q.pos_x     <= rf_q[RF_PX][47:0];
                out_q.pos_y     <= rf_q[RF_PY][47:0];
                out_q.pos_z     <= rf_q[RF_PZ][47:0];
                out_q.vel_x     <= rf_q[RF_VX][47:0];
                out_q.vel_y     <= rf_q[RF_VY][47:0];
                out_q.vel_z     <= rf_q[RF_VZ][47:0];
                out_q.quat_w    <= rf_q[RF_QW][31:0];
                out_q.quat_x    <= rf_q[RF_QX][31:0];
                out_q.quat_y    <= rf_q[RF_QY][31:0];
                out_q.quat_z    <= rf_q[RF_QZ][31:0];
                out_q.stamp_out <= stamp_q;
                state_q         <= S_IDLE;
              end
            end
            default: pc_q <= pc_q + PcW'(1);
          endcase
        end
        S_LDB: state_q <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            pc_q    <= pc_q + PcW'(1);
            state_q <= S_FETCH;
          end
        end
        S_NMAX: begin
          if (rd_abs[47:0] > m_q) begin
            m_q <= rd_abs[47:0];
          end
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_q <= S_NSRCH;
          end
        end
        S_NSRCH: begin
          // Move the largest magnitude into [2^29, 2^30) one bit per cycle.
          priority if (m_q == '0) begin
            zero_q  <= 1'b1;
            state_q <= S_NAPPLY;
          end else if (m_q >= 48'h4000_0000) begin
            m_q   <= m_q >> 1;
            k_q   <= k_q + 5'd1;
            dir_q <= 1'b1;
          end else if (m_q < 48'h2000_0000) begin
            m_q <= m_q << 1;
            k_q <= k_q + 5'd1;
          end else begin
            state_q <= S_NAPPLY;
          end
        end
        S_NAPPLY: begin
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            pc_q    <= zero_q ? PC_ROT : pc_q + PcW'(1);
            state_q <= S_FETCH;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_WAIT)
    else $error("multiplier result arrived outside the wait state");
  a_div_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> !first_q)
    else $error("dt division started on the first sample");
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q < ItW'(NORM_ITERATIONS))
    else $error("Newton iteration count out of range");
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NAPPLY && !zero_q) |-> (m_q >= 48'h2000_0000 && m_q < 48'h4000_0000))
    else $error("normalizing shift left the magnitude out of range");
`endif

endmodule

@@ design/imuint_mul.sv @@
// Shared signed multiplier with round-to-nearest (ties away from zero), shift and
// magnitude limit. 48x48 magnitudes through one 24x24 partial product per cycle.
// Depends on imuint_pkg.
module imuint_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  imuint_pkg::mul_ctl_t    ctl_i,
  input  logic signed [63:0]      a_i,
  input  logic signed [63:0]      b_i,
  output logic                    done_o,
  output logic signed [63:0]      res_o
);
  import imuint_pkg::*;

  logic [2:0]  step_q;
  logic [47:0] ma_q, mb_q;
  logic        neg_q;
  mul_ctl_t    ctl_q;
  logic [95:0] acc_q;
  logic        done_q;
  logic signed [63:0] res_q;

  logic [63:0] abs_a, abs_b;
  logic [23:0] pa, pb;
  logic [47:0] pp;
  logic [95:0] ppx;
  logic [96:0] half, sum, q;
  logic [63:0] lim, mag;

  assign abs_a = a_i[63] ? 64'(-a_i) : 64'(a_i);
  assign abs_b = b_i[63] ? 64'(-b_i) : 64'(b_i);

  always_comb begin
    pa  = ma_q[23:0];
    pb  = mb_q[23:0];
    unique case (step_q)
      3'd2:    pb = mb_q[47:24];
      3'd3:    pa = ma_q[47:24];
      3'd4: begin
        pa = ma_q[47:24];
        pb = mb_q[47:24];
      end
      default: ;
    endcase
    pp  = pa * pb;
    ppx = {48'b0, pp};
    unique case (step_q)
      3'd2, 3'd3: ppx = {24'b0, pp, 24'b0};
      3'd4:       ppx = {pp, 48'b0};
      default:    ;
    endcase
  end

  always_comb begin
    unique case (ctl_q.sh)
      SH_FRAC: half = 97'd1 << (FRAC_BITS - 1);
      SH_29:   half = 97'd1 << 28;
      SH_30:   half = 97'd1 << 29;
      SH_31:   half = 97'd1 << 30;
      default: half = '0;
    endcase
    sum = {1'b0, acc_q} + half;
    unique case (ctl_q.sh)
      SH_FRAC: q = sum >> FRAC_BITS;
      SH_29:   q = sum >> 29;
      SH_30:   q = sum >> 30;
      SH_31:   q = sum >> 31;
      default: q = sum;
    endcase
    unique case (ctl_q.lim)
      LIM_31:  lim = 64'h7FFF_FFFF;
      LIM_33:  lim = 64'd1 << 33;
      LIM_40:  lim = 64'd1 << 40;
      LIM_50:  lim = 64'd1 << 50;
      LIM_60:  lim = 64'd1 << 60;
      default: lim = '1;
    endcase
    mag = (q > {33'b0, lim}) ? lim : q[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= 3'd1;
      end else if (step_q == 3'd5) begin
        step_q <= '0;
        done_q <= 1'b1;
      end else if (step_q != 3'd0) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= abs_a[47:0];
      mb_q  <= abs_b[47:0];
      neg_q <= a_i[63] ^ b_i[63];
      ctl_q <= ctl_i;
      acc_q <= '0;
    end else if (step_q >= 3'd1 && step_q <= 3'd4) begin
      acc_q <= acc_q + ppx;
    end else if (step_q == 3'd5) begin
      res_q <= neg_q ? -$signed(mag) : $signed(mag);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> step_q == 3'd0)
    else $error("multiplier started while busy");
  a_done_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(step_q) == 3'd5)
    else $error("done without a rounding cycle");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 3'd5)
    else $error("multiplier step out of range");
`endif

endmodule
